// ----- rtl/core/i2a_pkg.sv -----
package i2a_pkg;

    // number of decimal digits printed after the sign
    localparam int DIGIT_COUNT = 6;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    // 10^DIGIT_COUNT and 10^(DIGIT_COUNT-1)
    localparam longint unsigned MOD_VALUE = 64'd10 ** DIGIT_COUNT;
    localparam longint unsigned TOP_VALUE = 64'd10 ** (DIGIT_COUNT - 1);

    // fixed-point reciprocal of MOD_VALUE, scaled by 2^VALUE_W
    localparam longint unsigned RECIP_VALUE = (64'd1 << VALUE_W) / MOD_VALUE;

    localparam int REM_W = $clog2(MOD_VALUE);
    localparam int CNT_W = $clog2(DIGIT_COUNT + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef logic [REM_W-1:0] t_rem;

    // sign and low decimal digits of one value, passed to the serializer
    typedef struct packed {
        logic neg;
        t_rem rem;
    } t_mod_word;

endpackage

// ----- rtl/core/i2a_reduce.sv -----
module i2a_reduce
    import i2a_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_mod_word                 o_word
);

    localparam logic [VALUE_W-1:0] RECIP_C = VALUE_W'(RECIP_VALUE);
    localparam logic [REM_W:0]     MOD_C   = (REM_W + 1)'(MOD_VALUE);

    // stage 1: sign and magnitude
    logic               r_v1;
    logic               r_neg1;
    logic [VALUE_W-1:0] r_mag1;
    // stage 2: quotient estimate
    logic               r_v2;
    logic               r_neg2;
    logic [VALUE_W-1:0] r_mag2;
    logic [VALUE_W-1:0] r_quo2;
    // stage 3: remainder
    logic               r_v3;
    t_mod_word          r_word3;

    logic                 w_ready1;
    logic                 w_ready2;
    logic                 w_ready3;
    logic [VALUE_W-1:0]   w_mag;
    logic [2*VALUE_W-1:0] w_prod;
    logic [2*VALUE_W-1:0] w_back;
    logic [2*VALUE_W-1:0] w_diff;
    logic [REM_W:0]       w_part;
    t_rem                 w_rem;

    assign w_ready3 = !r_v3 || i_ready;
    assign w_ready2 = !r_v2 || w_ready3;
    assign w_ready1 = !r_v1 || w_ready2;
    assign o_ready  = w_ready1;
    assign o_valid  = r_v3;
    assign o_word   = r_word3;

    // two's complement magnitude, the most negative value maps to 2^31
    assign w_mag  = i_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(i_value)) : VALUE_W'(i_value);

    // estimate may fall one short of the true quotient
    assign w_prod = r_mag1 * RECIP_C;
    assign w_back = (2*VALUE_W)'(r_quo2) * MOD_VALUE;
    assign w_diff = (2*VALUE_W)'(r_mag2) - w_back;
    assign w_part = w_diff[REM_W:0];
    assign w_rem  = (w_part >= MOD_C) ? REM_W'(w_part - MOD_C) : REM_W'(w_part);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ready1) begin
                r_v1 <= i_valid;
            end
            if (w_ready2) begin
                r_v2 <= r_v1;
            end
            if (w_ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1) begin
            r_neg1 <= i_value[VALUE_W-1];
            r_mag1 <= w_mag;
        end
        if (w_ready2) begin
            r_neg2 <= r_neg1;
            r_mag2 <= r_mag1;
            r_quo2 <= w_prod[2*VALUE_W-1:VALUE_W];
        end
        if (w_ready3) begin
            r_word3.neg <= r_neg2;
            r_word3.rem <= w_rem;
        end
    end

endmodule

// ----- rtl/core/i2a_serial.sv -----
module i2a_serial
    import i2a_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_mod_word         i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    t_rem             r_rem;

    logic [DIGIT_W-1:0] w_digit;
    t_rem               w_sub;
    t_rem               w_low;
    t_rem               w_next;
    logic               w_sign;

    // leading digit: how many multiples of the top weight fit
    always_comb begin
        w_digit = '0;
        w_sub   = '0;
        for (int k = 1; k < 10; k++) begin
            if (r_rem >= REM_W'(64'(k) * TOP_VALUE)) begin
                w_digit = DIGIT_W'(k);
                w_sub   = REM_W'(64'(k) * TOP_VALUE);
            end
        end
    end

    assign w_low  = r_rem - w_sub;
    assign w_next = REM_W'(w_low * REM_W'(10));
    assign w_sign = (r_cnt == '0);

    assign o_valid = r_busy;
    assign o_last  = r_busy && (r_cnt == CNT_W'(DIGIT_COUNT));
    assign o_char  = w_sign ? (r_neg ? CHAR_MINUS : CHAR_PLUS)
                            : (CHAR_ZERO + CHAR_W'(w_digit));
    assign o_ready = !r_busy || (i_ready && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_ready && i_valid) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy && i_ready) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_neg <= i_word.neg;
            r_rem <= i_word.rem;
        end else if (r_busy && i_ready && !w_sign) begin
            r_rem <= w_next;
        end
    end

endmodule

// ----- rtl/core/signed_int_to_ascii_decimal.sv -----
// signed integer to fixed-width ascii decimal text
//
// slave stream: one word per value, tdata holds the two's complement integer.
// master stream: one word per character, tdata holds the ascii code, tlast
// marks the final digit. each value gives a sign ('+' or '-', zero counts as
// '+') followed by DIGIT_COUNT digits, most significant first; digits above
// the low DIGIT_COUNT ones are dropped.
//
// pipeline: the sign character is presented once the input word has passed
// the three front stages (sign/magnitude, reciprocal multiply, remainder) and
// been loaded into the serializer. each value holds the single character
// output port for DIGIT_COUNT+1 characters; the three front stages and the
// serializer buffer up to four values, so four words are taken back to back
// before s_axis_tready falls back to one word per output run.
// reset (i_rst_n low at a clock edge) empties all stages; no word is shown
// afterwards. a master-side stall freezes the current character and fills
// the front stages before s_axis_tready drops.
module signed_int_to_ascii_decimal
    import i2a_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic signed [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [CHAR_W-1:0]         m_axis_tdata,   // [7:0] text_char
    output logic                      m_axis_tlast    // last_char
);

    t_mod_word w_word;
    logic      w_word_valid;
    logic      w_word_ready;

    // tracks whether the next character shown is a sign
    logic r_expect_sign;

    // front end: value to sign and low decimal digits
    i2a_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_value (s_axis_tdata),
        .o_valid (w_word_valid),
        .i_ready (w_word_ready),
        .o_word  (w_word)
    );

    // back end: one character per master word
    i2a_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_word_valid),
        .o_ready (w_word_ready),
        .i_word  (w_word),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_sign <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_expect_sign <= m_axis_tlast;
        end
    end

    // first character of each run is a sign
    a_sign_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_expect_sign) |->
            (m_axis_tdata == CHAR_PLUS || m_axis_tdata == CHAR_MINUS))
        else $error("run does not start with a sign character");

    // every other character is a decimal digit
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_expect_sign) |->
            (m_axis_tdata >= CHAR_ZERO && m_axis_tdata <= CHAR_ZERO + CHAR_W'(9)))
        else $error("digit character out of range");

    // the sign character never carries tlast
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_expect_sign) |-> !m_axis_tlast)
        else $error("tlast on a sign character");

endmodule
